>>> hw/rtl/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the bitmap row run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 8;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_REPEAT_CODE      = 3'd0,
    REG_ZERO_RUN_CODE    = 3'd1,
    REG_ONES_RUN_CODE    = 3'd2,
    REG_DOUBLE_ZERO_CODE = 3'd3,
    REG_DOUBLE_ONES_CODE = 3'd4,
    REG_VERSION_TWO_MODE = 3'd5,
    REG_COMPRESS_ENABLE  = 3'd6
  } reg_index_t;

  localparam logic [7:0] RepeatCodeReset     = 8'h31;
  localparam logic [7:0] ZeroRunCodeReset    = 8'h8C;
  localparam logic [7:0] OnesRunCodeReset    = 8'hCC;
  localparam logic [7:0] DoubleZeroCodeReset = 8'h39;
  localparam logic [7:0] DoubleOnesCodeReset = 8'h9C;

  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOnes = 8'hFF;
  localparam logic [7:0] RunMax   = 8'd255;

  localparam logic OpPixel  = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic [7:0] repeat_code;
    logic [7:0] zero_run_code;
    logic [7:0] ones_run_code;
    logic [7:0] double_zero_code;
    logic [7:0] double_ones_code;
    logic       version_two_mode;
    logic       compress_enable;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_byte;
    logic [3:0] valid_bits;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } res_t;

endpackage

>>> hw/rtl/brle_cfg.sv
// ----------------------------------------------------------------------------
// brle_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module brle_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [brle_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [brle_pkg::CfgDataWidth-1:0]   cfg_data,
  output brle_pkg::cfg_t                      cfg
);
  import brle_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_code      <= RepeatCodeReset;
      cfg.zero_run_code    <= ZeroRunCodeReset;
      cfg.ones_run_code    <= OnesRunCodeReset;
      cfg.double_zero_code <= DoubleZeroCodeReset;
      cfg.double_ones_code <= DoubleOnesCodeReset;
      cfg.version_two_mode <= 1'b0;
      cfg.compress_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPEAT_CODE:      cfg.repeat_code      <= cfg_data;
        REG_ZERO_RUN_CODE:    cfg.zero_run_code    <= cfg_data;
        REG_ONES_RUN_CODE:    cfg.ones_run_code    <= cfg_data;
        REG_DOUBLE_ZERO_CODE: cfg.double_zero_code <= cfg_data;
        REG_DOUBLE_ONES_CODE: cfg.double_ones_code <= cfg_data;
        REG_VERSION_TWO_MODE: cfg.version_two_mode <= cfg_data[0];
        REG_COMPRESS_ENABLE:  cfg.compress_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/brle_encode.sv
// ----------------------------------------------------------------------------
// brle_encode
// Pixel byte conditioning, run tracking and flush code selection.
// ----------------------------------------------------------------------------
module brle_encode (
  input  logic            clk,
  input  logic            rst,
  input  brle_pkg::cfg_t  cfg,
  input  brle_pkg::item_t item,
  input  logic            fire,
  output brle_pkg::res_t  res
);
  import brle_pkg::*;

  logic [7:0] run_value;
  logic [7:0] run_length;
  logic [7:0] run_value_next;
  logic [7:0] run_length_next;
  logic [7:0] padded;
  logic [7:0] proc_byte;
  logic       extreme;
  logic       is_code;
  logic       literal;
  res_t       flush;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      padded[i] = item.pixel_byte[i] | (item.valid_bits <= 4'(i));
    end
    for (int i = 0; i < 8; i++) begin
      proc_byte[7-i] = padded[i] ^ ~cfg.version_two_mode;
    end
  end

  assign extreme = (run_value == ByteZero) || (run_value == ByteOnes);
  assign is_code = (run_value == cfg.repeat_code) || (run_value == cfg.zero_run_code) ||
                   (run_value == cfg.ones_run_code) || (run_value == cfg.double_zero_code) ||
                   (run_value == cfg.double_ones_code);
  assign literal = ((run_length == 8'd1 && extreme) || (run_length <= 8'd3 && !extreme)) &&
                   !is_code;

  always_comb begin
    flush = '0;
    if (run_length == 8'd0) begin
      flush.cnt = 2'd0;
    end else if (literal) begin
      flush.cnt   = run_length[1:0];
      flush.byte0 = run_value;
      flush.byte1 = run_value;
      flush.byte2 = run_value;
    end else if (run_value == ByteZero || run_value == ByteOnes) begin
      if (run_length == 8'd2) begin
        flush.cnt   = 2'd1;
        flush.byte0 = (run_value == ByteZero) ? cfg.double_zero_code : cfg.double_ones_code;
      end else begin
        flush.cnt   = 2'd2;
        flush.byte0 = (run_value == ByteZero) ? cfg.zero_run_code : cfg.ones_run_code;
        flush.byte1 = run_length;
      end
    end else begin
      flush.cnt   = 2'd3;
      flush.byte0 = cfg.repeat_code;
      flush.byte1 = run_value;
      flush.byte2 = run_length;
    end
  end

  always_comb begin
    res             = '0;
    run_value_next  = run_value;
    run_length_next = run_length;
    if (item.opcode == OpFinish) begin
      if (cfg.compress_enable) begin
        res             = flush;
        run_value_next  = ByteZero;
        run_length_next = 8'd0;
      end
    end else if (!cfg.compress_enable) begin
      res.cnt   = 2'd1;
      res.byte0 = proc_byte;
    end else if (proc_byte == run_value && run_length != RunMax) begin
      run_length_next = run_length + 8'd1;
    end else begin
      res             = flush;
      run_value_next  = proc_byte;
      run_length_next = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value  <= ByteZero;
      run_length <= 8'd0;
    end else if (fire) begin
      run_value  <= run_value_next;
      run_length <= run_length_next;
    end
  end

  a_pixel_leaves_run: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OpPixel && cfg.compress_enable |=> run_length != 8'd0)
    else $error("pixel item left no pending run");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OpFinish && cfg.compress_enable |=>
      run_length == 8'd0 && run_value == ByteZero)
    else $error("finish did not clear the run");

  a_flush_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OpPixel && cfg.compress_enable && res.cnt != 2'd0 |=>
      run_length == 8'd1)
    else $error("flush on pixel item did not restart the run");

endmodule

>>> hw/rtl/brle_obuf.sv
// ----------------------------------------------------------------------------
// brle_obuf
// Result buffer holding up to three bytes of one item, drained one per beat.
// ----------------------------------------------------------------------------
module brle_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  brle_pkg::res_t res,
  output logic           can_load,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,   // out_byte[7:0]
  output logic           m_tlast
);
  import brle_pkg::*;

  logic [1:0] cnt;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic       take;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = b0;
  assign m_tlast  = (cnt == 2'd1);
  assign take     = m_tvalid && m_tready;
  assign can_load = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b0 <= res.byte0;
      b1 <= res.byte1;
      b2 <= res.byte2;
    end else if (take) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cnt > 2'd1 |-> !load)
    else $error("result buffer overwritten while draining");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> cnt == $past(res.cnt))
    else $error("result buffer count wrong after load");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |-> res.cnt != 2'd0)
    else $error("empty result loaded");

endmodule

>>> hw/rtl/bitmap_row_rle_encoder_core.sv
// ----------------------------------------------------------------------------
// bitmap_row_rle_encoder_core
// Escape-code run-length encoder for bitmap rows.
//
// Input stream s_*: one item per transfer. s_tuser is the opcode (0 pixel
// byte, 1 finish), s_tdata carries the pixel byte and its valid bit count.
// Output stream m_*: one encoded byte per transfer, m_tlast marks the final
// byte caused by one input item. An item produces zero to three bytes.
// Configuration: cfg_we writes cfg_data to register cfg_index at the edge.
// The first byte of an item is offered once the item has left the input
// register and its bytes have been loaded into the result buffer.
// Throughput: one item per cycle when the item yields at most one byte and
// the receiver does not stall; an item yielding more bytes holds the
// output while the single output port drains the buffer one byte per beat.
// Reset clears the pending run, the buffers and restores register defaults.
// When the receiver stalls, results hold in the buffer. An item that yields
// bytes waits in the input register until the buffer is empty or its last
// byte is being taken, and input is back-pressured while it waits. Items
// that yield no byte never wait.
// ----------------------------------------------------------------------------
module bitmap_row_rle_encoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // pixel_byte[7:0], valid_bits[11:8]
  input  logic                                s_tuser,   // opcode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // out_byte[7:0]
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [brle_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [brle_pkg::CfgDataWidth-1:0]   cfg_data
);
  import brle_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  res_t  res;
  logic  can_load;
  logic  fire;
  logic  accept;

  assign fire     = item_valid && (res.cnt == 2'd0 || can_load);
  assign s_tready = !item_valid || fire;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.opcode     <= s_tuser;
      item.pixel_byte <= s_tdata[7:0];
      item.valid_bits <= s_tdata[11:8];
    end
  end

  brle_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brle_encode u_encode (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .fire (fire),
    .res  (res)
  );

  brle_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res.cnt != 2'd0),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/bitmap_row_rle_encoder_core_test.sv
// ----------------------------------------------------------------------------
// bitmap_row_rle_encoder_core_test
// Self-checking bench for the bitmap row run-length encoder. A queue-fed
// driver offers pixel and finish items. Each accepted item is encoded by an
// in-bench model of padding, bit reversal, polarity and escape-code runs. A
// monitor compares every output transfer with the oldest predicted byte.
// Phases change the register settings while the block is idle and vary the
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
module bitmap_row_rle_encoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brle_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = OpPixel;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  item_t       pixel_items_q[$];
  item_t       offered_item;
  logic        offer_held = 1'b0;
  coded_byte_t coded_bytes_q[$];
  coded_byte_t wanted;
  logic [7:0]  burst_q[$];

  cfg_t        regs;
  logic [7:0]  run_val;
  logic [7:0]  run_len;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  bitmap_row_rle_encoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] bit_reverse(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = b[i];
    return r;
  endfunction

  function automatic logic [7:0] shape_byte(logic [7:0] pix, logic [3:0] vb);
    logic [7:0] padded;
    padded = pix;
    if (vb < 4'd8) padded = pix | (8'hFF << vb);
    return bit_reverse(padded) ^ (regs.version_two_mode ? ByteZero : ByteOnes);
  endfunction

  function automatic logic [7:0] pixel_for(logic [7:0] coded);
    return bit_reverse(coded ^ (regs.version_two_mode ? ByteZero : ByteOnes));
  endfunction

  function automatic logic is_escape(logic [7:0] b);
    return b == regs.repeat_code || b == regs.zero_run_code || b == regs.ones_run_code ||
           b == regs.double_zero_code || b == regs.double_ones_code;
  endfunction

  function automatic void flush_pending();
    logic extreme;
    extreme = run_val == ByteZero || run_val == ByteOnes;
    if (run_len == 0) return;
    if (((run_len == 1 && extreme) || (run_len <= 3 && !extreme)) && !is_escape(run_val)) begin
      for (int i = 0; i < run_len; i++) burst_q.push_back(run_val);
    end else if (run_val == ByteZero) begin
      if (run_len == 2) begin
        burst_q.push_back(regs.double_zero_code);
      end else begin
        burst_q.push_back(regs.zero_run_code);
        burst_q.push_back(run_len);
      end
    end else if (run_val == ByteOnes) begin
      if (run_len == 2) begin
        burst_q.push_back(regs.double_ones_code);
      end else begin
        burst_q.push_back(regs.ones_run_code);
        burst_q.push_back(run_len);
      end
    end else begin
      burst_q.push_back(regs.repeat_code);
      burst_q.push_back(run_val);
      burst_q.push_back(run_len);
    end
    run_val = ByteZero;
    run_len = '0;
  endfunction

  function automatic void encode_item(item_t it);
    logic [7:0] b;
    burst_q.delete();
    if (it.opcode == OpFinish) begin
      if (regs.compress_enable) flush_pending();
    end else begin
      b = shape_byte(it.pixel_byte, it.valid_bits);
      if (!regs.compress_enable) begin
        burst_q.push_back(b);
      end else if (b == run_val && run_len <= 8'd254) begin
        run_len = run_len + 8'd1;
      end else begin
        flush_pending();
        run_val = b;
        run_len = 8'd1;
      end
    end
    foreach (burst_q[i])
      coded_bytes_q.push_back('{data: burst_q[i], last: i == burst_q.size() - 1});
  endfunction

  function automatic void report(string what, logic [7:0] exp_data, logic exp_last);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %02h last %0b, got %02h last %0b", $realtime, what, exp_data,
               exp_last, m_tdata, m_tlast);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (offer_held && s_tready) begin
        encode_item(offered_item);
        offer_held = 1'b0;
      end
      if (!offer_held && pixel_items_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        offered_item = pixel_items_q.pop_front();
        offer_held = 1'b1;
      end
      s_tvalid <= offer_held;
      s_tdata <= {4'b0000, offered_item.valid_bits, offered_item.pixel_byte};
      s_tuser <= offered_item.opcode;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (coded_bytes_q.size() == 0) begin
          report("unexpected byte", 8'h00, 1'b0);
        end else begin
          wanted = coded_bytes_q.pop_front();
          if (m_tdata !== wanted.data || m_tlast !== wanted.last)
            report("byte mismatch", wanted.data, wanted.last);
        end
      end
      m_tready <= $urandom_range(99) >= snk_stall_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REPEAT_CODE:      regs.repeat_code = val;
      REG_ZERO_RUN_CODE:    regs.zero_run_code = val;
      REG_ONES_RUN_CODE:    regs.ones_run_code = val;
      REG_DOUBLE_ZERO_CODE: regs.double_zero_code = val;
      REG_DOUBLE_ONES_CODE: regs.double_ones_code = val;
      REG_VERSION_TWO_MODE: regs.version_two_mode = val[0];
      REG_COMPRESS_ENABLE:  regs.compress_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic write_codes(logic [7:0] rep, logic [7:0] zr, logic [7:0] onr, logic [7:0] dz,
                             logic [7:0] d1);
    write_reg(REG_REPEAT_CODE, rep);
    write_reg(REG_ZERO_RUN_CODE, zr);
    write_reg(REG_ONES_RUN_CODE, onr);
    write_reg(REG_DOUBLE_ZERO_CODE, dz);
    write_reg(REG_DOUBLE_ONES_CODE, d1);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pixel_items_q.size() != 0 || offer_held || coded_bytes_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic void push_pixel(logic [7:0] pix, logic [3:0] vb);
    pixel_items_q.push_back('{opcode: OpPixel, pixel_byte: pix, valid_bits: vb});
  endfunction

  function automatic void push_finish();
    pixel_items_q.push_back('{opcode: OpFinish, pixel_byte: 8'($urandom_range(255)),
                              valid_bits: 4'($urandom_range(15))});
  endfunction

  function automatic void push_run(logic [7:0] coded, int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_pixel(pixel_for(coded), 4'($urandom_range(8, 15)));
  endfunction

  function automatic logic [7:0] pick_value();
    case ($urandom_range(6))
      0: return ByteZero;
      1: return ByteOnes;
      2: begin
        case ($urandom_range(4))
          0: return regs.repeat_code;
          1: return regs.zero_run_code;
          2: return regs.ones_run_code;
          3: return regs.double_zero_code;
          default: return regs.double_ones_code;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_random(int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        push_finish();
        len = 1;
      end else if (roll < 25) begin
        push_pixel(8'($urandom_range(255)), 4'($urandom_range(15)));
        len = 1;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        push_run(pick_value(), len);
      end
      sent += len;
    end
  endfunction

  initial begin
    regs = '{repeat_code: RepeatCodeReset, zero_run_code: ZeroRunCodeReset,
             ones_run_code: OnesRunCodeReset, double_zero_code: DoubleZeroCodeReset,
             double_ones_code: DoubleOnesCodeReset, version_two_mode: 1'b0,
             compress_enable: 1'b1};
    run_val = ByteZero;
    run_len = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings
    push_finish();
    push_pixel(8'hA5, 4'd0);
    push_pixel(8'h3C, 4'd15);
    push_pixel(8'h3C, 4'd8);
    push_pixel(8'h01, 4'd1);
    push_run(ByteZero, 2);
    push_run(ByteOnes, 1);
    push_run(ByteOnes, 2);
    push_run(ByteZero, 3);
    push_run(8'h5A, 3);
    push_run(8'hC3, 4);
    push_run(RepeatCodeReset, 1);
    push_run(ZeroRunCodeReset, 2);
    push_finish();
    push_finish();
    drain();

    src_idle_pct = 65;
    push_random(36);
    drain();

    write_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    write_reg(REG_VERSION_TWO_MODE, 8'd1);
    src_idle_pct = 0;
    snk_stall_pct = 65;
    push_run(ByteOnes, 257);
    push_finish();
    push_random(36);
    drain();

    write_reg(REG_COMPRESS_ENABLE, 8'd0);
    src_idle_pct = 9;
    snk_stall_pct = 9;
    push_random(36);
    drain();

    write_codes(ByteZero, ByteZero, ByteZero, ByteZero, ByteZero);
    write_reg(REG_VERSION_TWO_MODE, 8'd0);
    write_reg(REG_COMPRESS_ENABLE, 8'd1);
    src_idle_pct = 65;
    snk_stall_pct = 0;
    push_random(28);
    push_finish();
    drain();

    write_codes(ByteOnes, ByteOnes, ByteOnes, ByteOnes, ByteOnes);
    write_reg(REG_VERSION_TWO_MODE, 8'd1);
    src_idle_pct = 0;
    snk_stall_pct = 65;
    push_random(28);
    drain();

    write_codes(RepeatCodeReset, ZeroRunCodeReset, OnesRunCodeReset, DoubleZeroCodeReset,
                DoubleOnesCodeReset);
    write_reg(REG_VERSION_TWO_MODE, 8'd0);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    push_random(22);
    push_finish();
    drain();

    if (mismatch_count == 0 && coded_bytes_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> bitmap_row_rle_encoder_core.f
hw/rtl/brle_pkg.sv
hw/rtl/brle_cfg.sv
hw/rtl/brle_encode.sv
hw/rtl/brle_obuf.sv
hw/rtl/bitmap_row_rle_encoder_core.sv
tb/sv/bitmap_row_rle_encoder_core_test.sv
